/* sv/assert_macros.svh */
// assertion macros shared by the rtl modules
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds on every clock edge out of reset
`define ASSERT_ALWAYS(LBL, CLK, RSTN, A) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (A)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(LBL, CLK, RSTN, A, B) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (A) |-> (B)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(LBL, CLK, RSTN, A, B) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (A) |=> (B)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(LBL, CLK, RSTN, A)
`define ASSERT_IMPLY(LBL, CLK, RSTN, A, B)
`define ASSERT_NEXT(LBL, CLK, RSTN, A, B)

`endif

`endif

/* sv/vmle_pkg.sv */
// shared types and constants of the vu meter led frame encoder
// no dependencies
package vmle_pkg;

  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned GAIN_W    = 8;
  localparam int unsigned BYTE_W    = 8;
  // widest bar: full gain times up to 16 leds
  localparam int unsigned BAR_W     = 12;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LED_GAIN    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_BAR = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd32;

  // three marker bits then brightness 16
  localparam logic [BYTE_W-1:0] LED_HEADER = 8'hF0;

  localparam int unsigned FULL_SCALE = 15000;
  localparam int unsigned FS_W       = 14;

  localparam int unsigned SOF_BYTES     = 4;
  localparam int unsigned EOF_BYTES     = 5;
  localparam int unsigned BYTES_PER_LED = 4;

  // byte slot inside one led word
  localparam logic [1:0] SLOT_HEADER = 2'd0;
  localparam logic [1:0] SLOT_BLUE   = 2'd1;
  localparam logic [1:0] SLOT_GREEN  = 2'd2;
  localparam logic [1:0] SLOT_RED    = 2'd3;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              reverse;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [BAR_W-1:0] bar;
  } bar_xfer_t;

endpackage

/* sv/vmle_front.sv */
// front end: takes a meter level, scales it and divides by full scale
// depends on vmle_pkg and assert_macros.svh
`include "assert_macros.svh"

module vmle_front #(
  parameter int unsigned LED_COUNT = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [vmle_pkg::LEVEL_W-1:0] level,
  input  vmle_pkg::cfg_t                      cfg,
  input  logic                                q_full,
  output logic                                busy,
  output vmle_pkg::bar_xfer_t                 push
);
  import vmle_pkg::*;

  localparam int unsigned RAW_W   = LEVEL_W - 1;
  localparam int unsigned PROD_W  = RAW_W + BAR_W;
  // reciprocal of full scale, floor is exact for every product of PROD_W bits
  localparam int unsigned FS_SH   = PROD_W + FS_W;
  localparam int unsigned RECIP_W = PROD_W + 1;
  localparam int unsigned QP_W    = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] FS_RECIP =
    RECIP_W'(((64'd1 << FS_SH) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [RAW_W-1:0]  raw_r, raw_nxt;
  logic [BAR_W-1:0]  top_r, top_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [QP_W-1:0]   qprod;

  // divide by full scale as a multiply by its reciprocal
  assign qprod = QP_W'(quo_r) * QP_W'(FS_RECIP);

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    raw_nxt   = raw_r;
    top_nxt   = top_r;
    quo_nxt   = quo_r;
    push.valid = 1'b0;
    push.bar   = (quo_r > PROD_W'(top_r)) ? top_r : quo_r[BAR_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          // negative levels give an empty bar
          raw_nxt   = level[LEVEL_W-1] ? '0 : level[RAW_W-1:0];
          top_nxt   = BAR_W'(cfg.gain) * BAR_W'(LED_COUNT);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        quo_nxt   = PROD_W'(raw_r) * PROD_W'(top_r);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        quo_nxt   = PROD_W'(qprod >> FS_SH);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!q_full) begin
          push.valid = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r <= raw_nxt;
    top_r <= top_nxt;
    quo_r <= quo_nxt;
  end

  `ASSERT_NEXT(a_mul_to_div, clk, rst_n, state_r == S_MUL, state_r == S_DIV)
  `ASSERT_NEXT(a_accept_to_mul, clk, rst_n, start && !busy, state_r == S_MUL)
  `ASSERT_NEXT(a_push_to_idle, clk, rst_n, push.valid, state_r == S_IDLE)

endmodule

/* sv/vmle_queue.sv */
// two-entry queue of bar values between front and back
// depends on vmle_pkg and assert_macros.svh
`include "assert_macros.svh"

module vmle_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  vmle_pkg::bar_xfer_t push,
  input  logic                pop,
  output vmle_pkg::bar_xfer_t head,
  output logic                full
);
  import vmle_pkg::*;

  logic [BAR_W-1:0] ent_r [2];
  logic [1:0]       count_r, count_nxt;
  logic             wr_ptr_r, rd_ptr_r;

  assign head.valid = (count_r != 2'd0);
  assign head.bar   = ent_r[rd_ptr_r];
  assign full       = (count_r == 2'd2);

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push.valid) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push.valid) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      ent_r[wr_ptr_r] <= push.bar;
    end
  end

  `ASSERT_IMPLY(a_no_overflow, clk, rst_n, push.valid, !full)
  `ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, head.valid)
  `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_r <= 2'd2)

endmodule

/* sv/vmle_back.sv */
// back end: streams one led frame per bar value, one byte a cycle
// depends on vmle_pkg and assert_macros.svh
`include "assert_macros.svh"

module vmle_back #(
  parameter int unsigned LED_COUNT = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vmle_pkg::cfg_t              cfg,
  input  vmle_pkg::bar_xfer_t         head,
  output logic                        pop,
  output logic                        frame_strobe,
  output logic [vmle_pkg::BYTE_W-1:0] frame_byte,
  output logic                        frame_last
);
  import vmle_pkg::*;

  localparam int unsigned FRAME    = SOF_BYTES + BYTES_PER_LED * LED_COUNT + EOF_BYTES;
  localparam int unsigned CNT_W    = $clog2(FRAME);
  localparam int unsigned POS_W    = CNT_W - 2;
  localparam int unsigned LED_W    = $clog2(LED_COUNT);
  localparam int unsigned DEN      = LED_COUNT - 1;
  localparam int unsigned NUM_W    = $clog2((2 ** GAIN_W - 1) * DEN + 1);
  localparam int unsigned RECIP_SH = 20;
  localparam int unsigned RECIP_W  = RECIP_SH + 1;
  localparam int unsigned QP_W     = NUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SH + DEN - 1) / DEN);

  localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(FRAME - 1);
  localparam logic [CNT_W-1:0] LED_FIRST = CNT_W'(SOF_BYTES);
  localparam logic [CNT_W-1:0] LED_END   = CNT_W'(SOF_BYTES + BYTES_PER_LED * LED_COUNT);

  logic             running_r, running_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BAR_W-1:0] bar_r, bar_nxt;
  logic             frame_end;

  logic [POS_W-1:0]  pos;
  logic [LED_W-1:0]  led_calc;
  logic [LED_W-1:0]  led_r;
  logic [BAR_W-1:0]  base_r;
  logic [BAR_W-1:0]  diff;
  logic [GAIN_W-1:0] v_calc;
  logic [GAIN_W-1:0] v1_r, v2_r;
  logic [NUM_W-1:0]  num1_r, num2_r;
  logic [QP_W-1:0]   qprod;
  logic [GAIN_W-1:0] q2_r;
  logic [NUM_W-1:0]  rem;
  logic [GAIN_W-1:0] red_r, green_r;

  // frame sequencing
  assign frame_end = running_r && (cnt_r == LAST_CNT);
  assign pop       = head.valid && (!running_r || frame_end);

  always_comb begin
    running_nxt = running_r;
    cnt_nxt     = cnt_r;
    bar_nxt     = bar_r;
    if (pop) begin
      running_nxt = 1'b1;
      cnt_nxt     = '0;
      bar_nxt     = head.bar;
    end else if (frame_end) begin
      running_nxt = 1'b0;
      cnt_nxt     = '0;
    end else if (running_r) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      running_r <= running_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bar_r <= bar_nxt;
  end

  // color pipeline: four stages per led, result ready for the next led word
  assign pos = cnt_r[CNT_W-1:2];

  always_comb begin
    if (pos >= POS_W'(LED_COUNT)) begin
      led_calc = '0;
    end else if (cfg.reverse) begin
      led_calc = LED_W'(LED_COUNT - 1) - LED_W'(pos);
    end else begin
      led_calc = LED_W'(pos);
    end
  end

  assign diff = bar_r - base_r;

  always_comb begin
    if (bar_r <= base_r) begin
      v_calc = '0;
    end else if (diff > BAR_W'(cfg.gain)) begin
      v_calc = cfg.gain;
    end else begin
      v_calc = diff[GAIN_W-1:0];
    end
  end

  assign qprod = QP_W'(num1_r) * QP_W'(RECIP);
  assign rem   = num2_r - NUM_W'(q2_r) * NUM_W'(DEN);

  always_ff @(posedge clk) begin
    led_r  <= led_calc;
    base_r <= BAR_W'(led_calc) * BAR_W'(cfg.gain);
    v1_r   <= v_calc;
    num1_r <= NUM_W'(v_calc) * NUM_W'(led_r);
    v2_r   <= v1_r;
    num2_r <= num1_r;
    q2_r   <= GAIN_W'(qprod >> RECIP_SH);
    if (cnt_r[1:0] == SLOT_RED) begin
      red_r   <= q2_r;
      green_r <= v2_r - q2_r - GAIN_W'(rem != '0);
    end
  end

  // byte select
  always_comb begin
    frame_byte = '0;
    if ((cnt_r >= LED_FIRST) && (cnt_r < LED_END)) begin
      unique case (cnt_r[1:0])
        SLOT_HEADER: frame_byte = LED_HEADER;
        SLOT_BLUE:   frame_byte = '0;
        SLOT_GREEN:  frame_byte = green_r;
        SLOT_RED:    frame_byte = red_r;
        default:     frame_byte = '0;
      endcase
    end
  end

  assign frame_strobe = running_r;
  assign frame_last   = frame_end;

  `ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_r <= LAST_CNT)
  `ASSERT_NEXT(a_idle_after_frame, clk, rst_n, frame_end && !head.valid, !running_r)
  `ASSERT_IMPLY(a_idle_count_zero, clk, rst_n, !running_r, cnt_r == '0)

endmodule

/* sv/vu_meter_led_frame_encoder.sv */
// top level of the vu meter led frame encoder: config registers and wiring
// depends on vmle_pkg, vmle_front, vmle_queue and vmle_back

// Each meter level transferred in on start (accepted when busy is low)
// produces one complete led frame of 4*LED_COUNT+9 bytes (41 at eight leds),
// one byte per cycle on out_byte while out_strobe is high, with
// out_last_byte marking the final end byte. The receiver cannot stall:
// bytes of a frame come in consecutive cycles and frames for queued levels
// follow with no gap. In the front end a level passes a multiply, a
// reciprocal multiply for the divide by full scale, then a queue push;
// an idle back end pops the queued value and starts its frame. The
// sustained rate is one level per frame, set by the one-byte-per-cycle
// output stream. busy stays high while the front end works on a level or
// waits for room in the two-entry queue, so a new level is taken only once
// the last one is pushed. Config writes (index 0 led gain, index 1 reverse
// order) take effect at once and belong in idle periods.
module vu_meter_led_frame_encoder #(
  parameter int unsigned LED_COUNT = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [vmle_pkg::LEVEL_W-1:0]   in_meter_level,
  // result channel
  output logic                                  out_strobe,
  output logic [vmle_pkg::BYTE_W-1:0]           out_byte,
  output logic                                  out_last_byte,
  // config write port
  input  logic                                  cfg_we,
  input  logic [vmle_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vmle_pkg::GAIN_W-1:0]           cfg_data
);
  import vmle_pkg::*;

  logic [GAIN_W-1:0] gain_r, gain_nxt;
  logic              reverse_r, reverse_nxt;
  cfg_t              cfg;
  bar_xfer_t         push;
  bar_xfer_t         head;
  logic              q_full;
  logic              pop;

  // config registers, no read-back
  always_comb begin
    gain_nxt    = gain_r;
    reverse_nxt = reverse_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LED_GAIN:    gain_nxt    = cfg_data;
        CFG_REVERSE_BAR: reverse_nxt = cfg_data[0];
        default:         gain_nxt    = gain_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= GAIN_RESET;
      reverse_r <= 1'b0;
    end else begin
      gain_r    <= gain_nxt;
      reverse_r <= reverse_nxt;
    end
  end

  assign cfg.gain    = gain_r;
  assign cfg.reverse = reverse_r;

  // front end: level to clamped bar value
  vmle_front #(
    .LED_COUNT(LED_COUNT)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .level  (in_meter_level),
    .cfg    (cfg),
    .q_full (q_full),
    .busy   (busy),
    .push   (push)
  );

  // decouples front end latency from the byte stream
  vmle_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  // back end: bar value to frame bytes
  vmle_back #(
    .LED_COUNT(LED_COUNT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .head         (head),
    .pop          (pop),
    .frame_strobe (out_strobe),
    .frame_byte   (out_byte),
    .frame_last   (out_last_byte)
  );

endmodule

/* test/tb_top.sv */
// self-checking testbench for vu_meter_led_frame_encoder: meter levels in, led frame bytes out
// checks every frame byte against a built-in frame predictor
// depends on vmle_pkg and the vu_meter_led_frame_encoder rtl
module tb_top;
  import vmle_pkg::*;

  localparam int unsigned LEDS         = 8;
  localparam int unsigned FRAME_BYTES  = SOF_BYTES + BYTES_PER_LED * LEDS + EOF_BYTES;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned TAIL_CYCLES  = 80;
  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam int unsigned MAX_REPORTS  = 10;

  // what the driver does with one queue entry
  typedef enum logic [1:0] {
    STEP_LEVEL,  // send one meter level
    STEP_WRITE,  // register write, only once the block is quiet
    STEP_QUIET,  // hold the sender until every expected byte has come
    STEP_PACE    // change the sender idle percentage
  } step_kind_t;

  typedef struct {
    step_kind_t                kind;
    logic [LEVEL_W-1:0]        level;
    logic [CFG_IDX_W-1:0]      index;
    logic [GAIN_W-1:0]         data;
  } step_t;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // block inputs, all known from time zero
  logic                        start = 1'b0;
  logic signed [LEVEL_W-1:0]   in_meter_level = '0;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = CFG_LED_GAIN;
  logic [GAIN_W-1:0]           cfg_data = '0;

  // block outputs
  logic                        busy;
  logic                        out_strobe;
  logic [BYTE_W-1:0]           out_byte;
  logic                        out_last_byte;

  step_t       pending_steps[$];
  frame_byte_t expected_bytes[$];

  // register copies kept in step with the block
  logic [GAIN_W-1:0] gain_copy = GAIN_RESET;
  logic              reverse_copy = 1'b0;

  logic level_taken = 1'b0;   // a level transfer happened at the last rising edge
  int   quiet_cycles = 0;     // cycles with nothing expected and busy low
  int   cycle_cnt = 0;
  int   mismatches = 0;
  int   levels_sent = 0;
  int   frames_seen = 0;
  int   bytes_checked = 0;
  int   reg_writes = 0;
  int   idle_pct = 0;         // written by the driver only

  vu_meter_led_frame_encoder #(
    .LED_COUNT(LEDS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_meter_level(in_meter_level),
    .out_strobe    (out_strobe),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // frame predictor: scale the level to a bar, hand it out per led in portions
  // of at most the gain, fade each led from green to red, then lay out the frame
  function automatic void predict_frame(input logic signed [LEVEL_W-1:0] level);
    logic [31:0]       full_bar;
    logic [31:0]       bar;
    logic [31:0]       portion;
    logic [31:0]       scaled;
    logic [31:0]       red_part;
    logic [31:0]       used_up;
    logic [BYTE_W-1:0] red   [LEDS];
    logic [BYTE_W-1:0] green [LEDS];
    int                slot;
    full_bar = 32'(gain_copy) * LEDS;
    bar = '0;
    // negative levels leave the bar empty
    if (!level[LEVEL_W-1]) begin
      bar = (32'(unsigned'(level)) * full_bar) / FULL_SCALE;
      if (bar > full_bar) begin
        bar = full_bar;
      end
    end
    for (int led = 0; led < LEDS; led++) begin
      if (bar > gain_copy) begin
        portion = gain_copy;
        bar -= gain_copy;
      end else begin
        portion = bar;
        bar = '0;
      end
      scaled   = portion * led;
      red_part = scaled / (LEDS - 1);                 // floor
      used_up  = (scaled + LEDS - 2) / (LEDS - 1);    // ceiling
      slot = reverse_copy ? (LEDS - 1 - led) : led;
      red[slot]   = red_part[BYTE_W-1:0];
      green[slot] = BYTE_W'(portion - used_up);
    end
    for (int i = 0; i < SOF_BYTES; i++) begin
      expected_bytes.push_back('{value: 8'h00, last: 1'b0});
    end
    for (int i = 0; i < LEDS; i++) begin
      expected_bytes.push_back('{value: LED_HEADER, last: 1'b0});
      expected_bytes.push_back('{value: 8'h00, last: 1'b0});
      expected_bytes.push_back('{value: green[i], last: 1'b0});
      expected_bytes.push_back('{value: red[i], last: 1'b0});
    end
    for (int i = 0; i < EOF_BYTES; i++) begin
      expected_bytes.push_back('{value: 8'h00, last: (i == EOF_BYTES - 1)});
    end
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch: %s at cycle %0d, expected %0d, got %0d", what, cycle_cnt, want, got);
    end
  endtask

  // monitor: sample at the rising edge, check bytes, then record new transfers
  always @(posedge clk) begin : monitor_proc
    frame_byte_t want;
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d bytes still expected",
               cycle_cnt, expected_bytes.size());
      $display("[vu_meter_led_frame_encoder] ERROR");
      $finish;
    end else if (!rst_n) begin
      gain_copy    = GAIN_RESET;
      reverse_copy = 1'b0;
      level_taken  <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      // check the byte leaving this cycle before any new frame is queued
      if (out_strobe) begin
        if (expected_bytes.size() == 0) begin
          // -1 stands for no byte expected
          flag_mismatch("byte with no frame pending", -1, out_byte);
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (out_byte !== want.value) begin
            flag_mismatch("out_byte", want.value, out_byte);
          end
          if (out_last_byte !== want.last) begin
            flag_mismatch("out_last_byte", want.last, out_last_byte);
          end
          if (want.last) begin
            frames_seen++;
          end
        end
      end
      // register writes land only while quiet, so the copy can follow at once
      if (cfg_we) begin
        reg_writes++;
        case (cfg_index)
          CFG_LED_GAIN:    gain_copy = cfg_data;
          CFG_REVERSE_BAR: reverse_copy = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        levels_sent++;
        predict_frame(in_meter_level);
      end
      level_taken <= start && !busy;
      if (expected_bytes.size() == 0 && !busy) begin
        quiet_cycles <= quiet_cycles + 1;
      end else begin
        quiet_cycles <= 0;
      end
    end
  end

  // driver: works through the step queue at the falling edge, one change per signal
  always @(negedge clk) begin : driver_proc
    logic                      nxt_start;
    logic signed [LEVEL_W-1:0] nxt_level;
    logic                      nxt_we;
    logic [CFG_IDX_W-1:0]      nxt_index;
    logic [GAIN_W-1:0]         nxt_data;
    logic                      quiet;
    nxt_start = start;
    nxt_level = in_meter_level;
    nxt_we    = 1'b0;
    nxt_index = cfg_index;
    nxt_data  = cfg_data;
    quiet     = (expected_bytes.size() == 0) && !busy && (quiet_cycles >= SETTLE);
    if (!rst_n) begin
      nxt_start = 1'b0;
    end else if (start && !level_taken) begin
      // level still waiting for busy to drop, keep it up
    end else begin
      nxt_start = 1'b0;
      if (pending_steps.size() != 0) begin
        case (pending_steps[0].kind)
          STEP_LEVEL: begin
            if ($urandom_range(99) >= idle_pct) begin
              nxt_start = 1'b1;
              nxt_level = pending_steps[0].level;
              void'(pending_steps.pop_front());
            end
          end
          STEP_WRITE: begin
            if (quiet) begin
              nxt_we    = 1'b1;
              nxt_index = pending_steps[0].index;
              nxt_data  = pending_steps[0].data;
              void'(pending_steps.pop_front());
            end
          end
          STEP_QUIET: begin
            if (quiet) begin
              void'(pending_steps.pop_front());
            end
          end
          STEP_PACE: begin
            idle_pct = pending_steps[0].data;
            void'(pending_steps.pop_front());
          end
          default: ;
        endcase
      end
    end
    start          <= nxt_start;
    in_meter_level <= nxt_level;
    cfg_we         <= nxt_we;
    cfg_index      <= nxt_index;
    cfg_data       <= nxt_data;
  end

  task automatic push_level(input int level);
    pending_steps.push_back('{kind: STEP_LEVEL, level: LEVEL_W'(level),
                              index: CFG_LED_GAIN, data: '0});
  endtask

  task automatic push_write(input logic [CFG_IDX_W-1:0] index, input logic [GAIN_W-1:0] data);
    pending_steps.push_back('{kind: STEP_WRITE, level: '0, index: index, data: data});
  endtask

  task automatic push_quiet();
    pending_steps.push_back('{kind: STEP_QUIET, level: '0, index: CFG_LED_GAIN, data: '0});
  endtask

  task automatic push_pace(input int pct);
    pending_steps.push_back('{kind: STEP_PACE, level: '0, index: CFG_LED_GAIN,
                              data: GAIN_W'(pct)});
  endtask

  // mostly in-range levels, some around full scale, some over the whole word
  function automatic int random_level();
    case ($urandom_range(9))
      0, 1, 2: return int'($urandom_range(16'hFFFF));
      3:       return 14980 + int'($urandom_range(40));
      4:       return int'($urandom_range(16'h7FFF));
      default: return int'($urandom_range(FULL_SCALE));
    endcase
  endfunction

  initial begin : stimulus_proc
    // corner levels at reset settings: zero, smallest step, full scale and
    // just below it, top of range, negatives, exact led boundaries, mid bar
    int corner_levels [12] = '{0, 1, 15000, 14999, 32767, -1, -32768,
                               1875, 1876, 7500, 3750, 16384};
    push_pace(27);
    foreach (corner_levels[i]) begin
      push_level(corner_levels[i]);
    end
    // widest gain, reversed bar
    push_write(CFG_LED_GAIN, 8'd255);
    push_write(CFG_REVERSE_BAR, 8'hFF);
    push_level(32767);
    push_level(15000);
    push_level(9000);
    push_level(-100);
    // zero gain keeps every led dark
    push_write(CFG_LED_GAIN, 8'd0);
    push_level(32767);
    push_level(5000);
    // smallest nonzero gain, normal order, upper data bits set on the reverse write
    push_write(CFG_LED_GAIN, 8'd1);
    push_write(CFG_REVERSE_BAR, 8'hFE);
    push_level(15000);
    push_level(14999);
    push_level(1875);

    // random segments: sender idles 27 percent, then 72, then never
    for (int seg = 0; seg < 6; seg++) begin
      push_pace(seg < 2 ? 27 : (seg < 4 ? 72 : 0));
      push_write(CFG_LED_GAIN, (seg == 0) ? 8'd255 :
                               (seg == 3) ? 8'd1 : GAIN_W'($urandom_range(255)));
      push_write(CFG_REVERSE_BAR, GAIN_W'($urandom));
      for (int n = 0; n < 18; n++) begin
        // once, the sender holds off until every byte in flight has come out
        if (seg == 4 && n == 9) begin
          push_quiet();
        end
        push_level(random_level());
      end
    end
    push_quiet();

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_steps.size() != 0 || start || expected_bytes.size() != 0) begin
      @(negedge clk);
    end
    // tail: make sure no stray bytes follow the last frame
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d meter levels, %0d frames, %0d bytes checked, %0d register writes",
             levels_sent, frames_seen, bytes_checked, reg_writes);
    $display("gains 0, 1, 255 and random, both bar directions, negative and over-range levels");
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("[vu_meter_led_frame_encoder] OK");
    end else begin
      $display("%0d mismatches, %0d bytes never seen", mismatches, expected_bytes.size());
      $display("[vu_meter_led_frame_encoder] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/vmle_pkg.sv
sv/vmle_front.sv
sv/vmle_queue.sv
sv/vmle_back.sv
sv/vu_meter_led_frame_encoder.sv
test/tb_top.sv
